/* hdl/owtr_pkg.sv */
// Package with the shared types, constants and helper functions of the one-wire temperature reader.
`default_nettype none
package owtr_pkg;

    localparam int WAIT_COUNTER_BITS = 20;
    localparam int DUR_W = 20;
    localparam logic [32:0] CNT_MAX = (33'd1 << WAIT_COUNTER_BITS) - 33'd1;

    localparam logic [DUR_W-1:0] RD_LOW_TIME    = DUR_W'(1);
    localparam logic [DUR_W-1:0] RD_SAMPLE_TIME = DUR_W'(10);
    localparam logic [DUR_W-1:0] RD_REST_TIME   = DUR_W'(50);
    localparam logic [DUR_W-1:0] ONE_TICK       = DUR_W'(1);

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [9:0] RESET_TIME_INIT    = 10'd480;
    localparam logic [7:0] PRESENCE_WAIT_INIT = 8'd60;
    localparam logic [7:0] SLOT_TIME_INIT     = 8'd60;
    localparam logic [19:0] CONV_WAIT_INIT    = 20'd750000;

    localparam logic [1:0] REG_RESET_TIME    = 2'd0;
    localparam logic [1:0] REG_PRESENCE_WAIT = 2'd1;
    localparam logic [1:0] REG_SLOT_TIME     = 2'd2;
    localparam logic [1:0] REG_CONV_WAIT     = 2'd3;

    localparam logic [2:0] STEP_CONVERT = 3'd2;
    localparam logic [2:0] STEP_LOW     = 3'd4;
    localparam logic [2:0] STEP_HIGH    = 3'd5;
    localparam logic [2:0] LAST_BIT     = 3'd7;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_RST_WAIT = 10'b00_0000_0100,
        PH_RST_REC  = 10'b00_0000_1000,
        PH_WR_LOW   = 10'b00_0001_0000,
        PH_WR_HIGH  = 10'b00_0010_0000,
        PH_RD_LOW   = 10'b00_0100_0000,
        PH_RD_WAIT  = 10'b00_1000_0000,
        PH_RD_REST  = 10'b01_0000_0000,
        PH_CONV     = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [9:0]  reset_time;
        logic [7:0]  presence_wait;
        logic [7:0]  slot_time;
        logic [19:0] conversion_wait;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        present;
        logic [15:0] temperature;
    } result_t;

    // Zero counts as one tick; long durations saturate at the counter range.
    function automatic logic [WAIT_COUNTER_BITS-1:0] sat_dur(input logic [DUR_W-1:0] d);
        logic [32:0] wide;
        wide = {{(33-DUR_W){1'b0}}, d};
        if (wide == 33'd0)
        begin
            wide = 33'd1;
        end
        if (wide > CNT_MAX)
        begin
            wide = CNT_MAX;
        end
        return wide[WAIT_COUNTER_BITS-1:0];
    endfunction

    // Command sequence: skip-ROM, convert, skip-ROM, read scratchpad.
    function automatic logic cmd_bit(input logic [2:0] step, input logic [2:0] bit_idx);
        logic [7:0] cmd;
        case (step[1:0])
            2'd0:    cmd = CMD_SKIP_ROM;
            2'd1:    cmd = CMD_CONVERT;
            2'd2:    cmd = CMD_SKIP_ROM;
            default: cmd = CMD_READ_PAD;
        endcase
        return cmd[bit_idx];
    endfunction

endpackage
`default_nettype wire

/* hdl/owtr_seq.sv */
// Bus sequencer: phase state, timing counter and the bit and byte shifting of one read.
`default_nettype none
module owtr_seq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step_en,
    input  wire                  kind,
    input  wire                  level,
    input  wire owtr_pkg::cfg_t  cfg,
    output owtr_pkg::result_t    result
);

    owtr_pkg::phase_t phase_reg, phase_next;
    logic [owtr_pkg::WAIT_COUNTER_BITS-1:0] time_count_reg, time_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [2:0]  byte_step_reg, byte_step_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        present_reg, present_next;
    logic [15:0] temp_hold_reg, temp_hold_next;

    logic        drive;
    logic        done;
    logic [2:0]  step_inc;
    logic [owtr_pkg::DUR_W-1:0] slot_dur;
    logic [owtr_pkg::DUR_W-1:0] presence_dur;
    logic [owtr_pkg::DUR_W-1:0] reset_dur;

    function automatic logic drive_of(input owtr_pkg::phase_t ph);
        return (ph == owtr_pkg::PH_RST_LOW) || (ph == owtr_pkg::PH_WR_LOW)
            || (ph == owtr_pkg::PH_RD_LOW);
    endfunction

    assign slot_dur     = {{(owtr_pkg::DUR_W-8){1'b0}}, cfg.slot_time};
    assign presence_dur = {{(owtr_pkg::DUR_W-8){1'b0}}, cfg.presence_wait};
    assign reset_dur    = {{(owtr_pkg::DUR_W-10){1'b0}}, cfg.reset_time};
    assign step_inc     = byte_step_reg + 3'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        time_count_next = time_count_reg;
        bit_index_next  = bit_index_reg;
        byte_step_next  = byte_step_reg;
        shift_byte_next = shift_byte_reg;
        low_byte_next   = low_byte_reg;
        present_next    = present_reg;
        temp_hold_next  = temp_hold_reg;
        drive           = 1'b0;
        done            = 1'b0;

        if (kind)
        begin
            if (phase_reg == owtr_pkg::PH_IDLE)
            begin
                byte_step_next  = 3'd0;
                bit_index_next  = 3'd0;
                shift_byte_next = 8'd0;
                low_byte_next   = 8'd0;
                present_next    = 1'b0;
                temp_hold_next  = 16'd0;
                phase_next      = owtr_pkg::PH_RST_LOW;
                time_count_next = owtr_pkg::sat_dur(reset_dur);
                drive           = 1'b1;
            end
            else
            begin
                drive = drive_of(phase_reg);
            end
        end
        else if (phase_reg != owtr_pkg::PH_IDLE)
        begin
            drive = drive_of(phase_reg);
            if (time_count_reg > owtr_pkg::WAIT_COUNTER_BITS'(1))
            begin
                time_count_next = time_count_reg - owtr_pkg::WAIT_COUNTER_BITS'(1);
            end
            else
            begin
                unique case (phase_reg)
                    owtr_pkg::PH_RST_LOW:
                    begin
                        phase_next      = owtr_pkg::PH_RST_WAIT;
                        time_count_next = owtr_pkg::sat_dur(presence_dur);
                    end
                    owtr_pkg::PH_RST_WAIT:
                    begin
                        if (byte_step_reg == 3'd0)
                        begin
                            present_next = ~level;
                        end
                        phase_next      = owtr_pkg::PH_RST_REC;
                        time_count_next = owtr_pkg::sat_dur(reset_dur);
                    end
                    owtr_pkg::PH_RST_REC:
                    begin
                        if (byte_step_reg == 3'd0 && !present_reg)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            bit_index_next  = 3'd0;
                            phase_next      = owtr_pkg::PH_WR_LOW;
                            time_count_next = owtr_pkg::sat_dur(
                                owtr_pkg::cmd_bit(byte_step_reg, 3'd0) ?
                                owtr_pkg::ONE_TICK : slot_dur);
                        end
                    end
                    owtr_pkg::PH_WR_LOW:
                    begin
                        phase_next      = owtr_pkg::PH_WR_HIGH;
                        time_count_next = owtr_pkg::sat_dur(
                            owtr_pkg::cmd_bit(byte_step_reg, bit_index_reg) ?
                            slot_dur : owtr_pkg::ONE_TICK);
                    end
                    owtr_pkg::PH_WR_HIGH:
                    begin
                        if (bit_index_reg != owtr_pkg::LAST_BIT)
                        begin
                            bit_index_next  = bit_index_reg + 3'd1;
                            phase_next      = owtr_pkg::PH_WR_LOW;
                            time_count_next = owtr_pkg::sat_dur(
                                owtr_pkg::cmd_bit(byte_step_reg, bit_index_reg + 3'd1) ?
                                owtr_pkg::ONE_TICK : slot_dur);
                        end
                        else
                        begin
                            bit_index_next = 3'd0;
                            byte_step_next = step_inc;
                            if (step_inc == owtr_pkg::STEP_CONVERT)
                            begin
                                phase_next      = owtr_pkg::PH_CONV;
                                time_count_next = owtr_pkg::sat_dur(cfg.conversion_wait);
                            end
                            else if (step_inc >= owtr_pkg::STEP_LOW)
                            begin
                                byte_step_next  = owtr_pkg::STEP_LOW;
                                shift_byte_next = 8'd0;
                                phase_next      = owtr_pkg::PH_RD_LOW;
                                time_count_next = owtr_pkg::sat_dur(owtr_pkg::RD_LOW_TIME);
                            end
                            else
                            begin
                                phase_next      = owtr_pkg::PH_WR_LOW;
                                time_count_next = owtr_pkg::sat_dur(
                                    owtr_pkg::cmd_bit(step_inc, 3'd0) ?
                                    owtr_pkg::ONE_TICK : slot_dur);
                            end
                        end
                    end
                    owtr_pkg::PH_CONV:
                    begin
                        phase_next      = owtr_pkg::PH_RST_LOW;
                        time_count_next = owtr_pkg::sat_dur(reset_dur);
                    end
                    owtr_pkg::PH_RD_LOW:
                    begin
                        phase_next      = owtr_pkg::PH_RD_WAIT;
                        time_count_next = owtr_pkg::sat_dur(owtr_pkg::RD_SAMPLE_TIME);
                    end
                    owtr_pkg::PH_RD_WAIT:
                    begin
                        if (level)
                        begin
                            shift_byte_next[bit_index_reg] = 1'b1;
                        end
                        phase_next      = owtr_pkg::PH_RD_REST;
                        time_count_next = owtr_pkg::sat_dur(owtr_pkg::RD_REST_TIME);
                    end
                    owtr_pkg::PH_RD_REST:
                    begin
                        if (bit_index_reg != owtr_pkg::LAST_BIT)
                        begin
                            bit_index_next  = bit_index_reg + 3'd1;
                            phase_next      = owtr_pkg::PH_RD_LOW;
                            time_count_next = owtr_pkg::sat_dur(owtr_pkg::RD_LOW_TIME);
                        end
                        else
                        begin
                            bit_index_next = 3'd0;
                            if (byte_step_reg == owtr_pkg::STEP_LOW)
                            begin
                                low_byte_next   = shift_byte_reg;
                                shift_byte_next = 8'd0;
                                byte_step_next  = owtr_pkg::STEP_HIGH;
                                phase_next      = owtr_pkg::PH_RD_LOW;
                                time_count_next = owtr_pkg::sat_dur(owtr_pkg::RD_LOW_TIME);
                            end
                            else
                            begin
                                temp_hold_next = {shift_byte_reg, low_byte_reg};
                                done           = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
                if (done)
                begin
                    phase_next      = owtr_pkg::PH_IDLE;
                    time_count_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        result.drive_low   = drive;
        result.busy_res    = (phase_next != owtr_pkg::PH_IDLE);
        result.done_res    = done;
        result.present     = present_next;
        result.temperature = (done && present_next) ? temp_hold_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= owtr_pkg::PH_IDLE;
            time_count_reg <= '0;
            bit_index_reg  <= 3'd0;
            byte_step_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            low_byte_reg   <= 8'd0;
            present_reg    <= 1'b0;
            temp_hold_reg  <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            time_count_reg <= time_count_next;
            bit_index_reg  <= bit_index_next;
            byte_step_reg  <= byte_step_next;
            shift_byte_reg <= shift_byte_next;
            low_byte_reg   <= low_byte_next;
            present_reg    <= present_next;
            temp_hold_reg  <= temp_hold_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/one_wire_temperature_reader.sv */
// Top level of the one-wire temperature reader: configuration registers and stream handshake.
//
//  channel   direction  tdata                                   tuser / tlast
//  s_*       in         [0] bus_level                           tuser[0] kind
//  m_*       out        [0] drive_low [1] busy_res [2] present  tlast done_res
//                       [18:3] temperature
//  cfg_*     in         write enable, register index, data      -
//
// On each accepted input transaction the sequencer updates its state and the
// result is captured in the output register, so one item can be accepted
// every clock while the output side keeps up. A stalled result holds the
// output register and input is paused only while it cannot be replaced.
// Reset is asynchronous and active low; configuration returns to its defaults.
`default_nettype none
module one_wire_temperature_reader (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [0] bus_level, [7:1] zero
    input  wire  [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] present,
                                   // [18:3] temperature, [23:19] zero
    output logic        m_tlast,   // done_res
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [19:0] cfg_wdata
);

    owtr_pkg::cfg_t    cfg_reg;
    owtr_pkg::result_t result;
    logic              accept;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;
    logic              m_last_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_time      <= owtr_pkg::RESET_TIME_INIT;
            cfg_reg.presence_wait   <= owtr_pkg::PRESENCE_WAIT_INIT;
            cfg_reg.slot_time       <= owtr_pkg::SLOT_TIME_INIT;
            cfg_reg.conversion_wait <= owtr_pkg::CONV_WAIT_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                owtr_pkg::REG_RESET_TIME:    cfg_reg.reset_time      <= cfg_wdata[9:0];
                owtr_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait   <= cfg_wdata[7:0];
                owtr_pkg::REG_SLOT_TIME:     cfg_reg.slot_time       <= cfg_wdata[7:0];
                owtr_pkg::REG_CONV_WAIT:     cfg_reg.conversion_wait <= cfg_wdata;
                default:                     cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    owtr_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .kind    (s_tuser[0]),
        .level   (s_tdata[0]),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {5'd0, result.temperature, result.present,
                           result.busy_res, result.drive_low};
            m_last_reg <= result.done_res;
        end
    end

endmodule
`default_nettype wire

/* hdl/owtr_chk.sv */
// Port-level checker for the one-wire temperature reader, bound to the top level.
`default_nettype none
module owtr_chk (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        m_tlast
);

    // A stalled result must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // The transaction that ends a sequence reports the block as no longer busy.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[1])
        else $error("sequence end reported while busy");

    // A temperature is only reported at the end of a read that found a device.
    a_temp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[18:3] != 16'd0) |-> m_tlast && m_tdata[2])
        else $error("temperature outside a finished read");

    // The line is only pulled low while a sequence runs.
    a_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("line driven while idle");

endmodule

bind one_wire_temperature_reader owtr_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
